// ----- hdl/sfc_pkg.sv -----
// Shared constants, codes and width helpers for the sphere frustum classifier.
package sfc_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 12;

  localparam int PLANE_BITS     = 64;
  localparam int NUM_PLANES     = 6;
  localparam int PERSP_PLANES   = 5;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ORTHO_MODE  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_FIRST = 3'd1;

  localparam logic [1:0] VERDICT_INSIDE  = 2'd0;
  localparam logic [1:0] VERDICT_PARTIAL = 2'd1;
  localparam logic [1:0] VERDICT_OUTSIDE = 2'd2;

  localparam int ROOT_BITS_PER_STAGE = 4;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int nrm_width(input int f);
    return f + 2;
  endfunction

  function automatic int ofs_width(input int f);
    return PLANE_BITS - 3 * nrm_width(f);
  endfunction

  function automatic int prod_width(input int cb, input int f);
    return nrm_width(f) + cb;
  endfunction

  function automatic int dist_width(input int cb, input int f);
    return max2(prod_width(cb, f) + 2, ofs_width(f) + f) + 1;
  endfunction

  function automatic int root_stages(input int cb);
    return (cb + ROOT_BITS_PER_STAGE - 1) / ROOT_BITS_PER_STAGE;
  endfunction

  function automatic int root_width(input int cb);
    return root_stages(cb) * ROOT_BITS_PER_STAGE;
  endfunction

endpackage

// ----- hdl/sfc_cfg_regs.sv -----
// Configuration registers: projection mode and the six packed frustum planes.
module sfc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sfc_pkg::PLANE_BITS-1:0]      cfg_data,
  output logic                                ortho_mode,
  output logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::PLANE_BITS-1:0] planes
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ortho_mode <= 1'b0;
      planes     <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == sfc_pkg::REG_ORTHO_MODE) begin
        ortho_mode <= cfg_data[0];
      end
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
        if (cfg_index == sfc_pkg::CFG_INDEX_BITS'(sfc_pkg::REG_PLANE_FIRST + p)) begin
          planes[p] <= cfg_data;
        end
      end
    end
  end

endmodule

// ----- hdl/sfc_front.sv -----
// Front stages: extent squares and plane products, then sum of squares and distances.
module sfc_front #(
  parameter int COORD_BITS       = sfc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = sfc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic signed [COORD_BITS-1:0]  center_z,
  input  logic [COORD_BITS-2:0]         extent_x,
  input  logic [COORD_BITS-2:0]         extent_y,
  input  logic [COORD_BITS-2:0]         extent_z,
  input  logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::PLANE_BITS-1:0] planes,
  output logic                          valid,
  output logic [2*COORD_BITS-1:0]       sumsq,
  output logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::dist_width(COORD_BITS, NORMAL_FRAC_BITS)-1:0]
                                        plane_dist
);

  localparam int NW = sfc_pkg::nrm_width(NORMAL_FRAC_BITS);
  localparam int OW = sfc_pkg::ofs_width(NORMAL_FRAC_BITS);
  localparam int PW = sfc_pkg::prod_width(COORD_BITS, NORMAL_FRAC_BITS);
  localparam int DW = sfc_pkg::dist_width(COORD_BITS, NORMAL_FRAC_BITS);
  localparam int EW = COORD_BITS - 1;
  localparam int QW = 2 * EW;
  localparam int SW = 2 * COORD_BITS;
  localparam int NP = sfc_pkg::NUM_PLANES;

  logic              valid1;
  logic [QW-1:0]     sq [3];
  logic signed [PW-1:0] prod [NP][3];
  logic signed [COORD_BITS-1:0] ctr [3];
  logic signed [DW-1:0] dist_next [NP];

  assign ctr[0] = center_x;
  assign ctr[1] = center_y;
  assign ctr[2] = center_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid  <= 1'b0;
    end else if (adv) begin
      valid1 <= in_valid;
      valid  <= valid1;
    end
  end

  always_comb begin
    logic signed [OW+NORMAL_FRAC_BITS-1:0] os;
    for (int p = 0; p < NP; p++) begin
      os = {planes[p][sfc_pkg::PLANE_BITS-1:3*NW], {NORMAL_FRAC_BITS{1'b0}}};
      dist_next[p] = DW'(prod[p][0]) + DW'(prod[p][1]) + DW'(prod[p][2]) - DW'(os);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0] <= QW'(extent_x) * QW'(extent_x);
      sq[1] <= QW'(extent_y) * QW'(extent_y);
      sq[2] <= QW'(extent_z) * QW'(extent_z);
      for (int p = 0; p < NP; p++) begin
        for (int k = 0; k < 3; k++) begin
          prod[p][k] <= $signed(planes[p][k*NW +: NW]) * ctr[k];
        end
      end
      sumsq <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      for (int p = 0; p < NP; p++) begin
        plane_dist[p] <= dist_next[p];
      end
    end
  end

endmodule

// ----- hdl/sfc_root_stage.sv -----
// One square root stage: four result bits, with the plane distances carried along.
module sfc_root_stage #(
  parameter int COORD_BITS       = sfc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = sfc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic valid_in,
  input  logic [2*sfc_pkg::root_width(COORD_BITS)-1:0] rad_in,
  input  logic [sfc_pkg::root_width(COORD_BITS)+1:0]   rem_in,
  input  logic [sfc_pkg::root_width(COORD_BITS)-1:0]   root_in,
  input  logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::dist_width(COORD_BITS, NORMAL_FRAC_BITS)-1:0]
               dist_in,
  output logic valid_out,
  output logic [2*sfc_pkg::root_width(COORD_BITS)-1:0] rad_out,
  output logic [sfc_pkg::root_width(COORD_BITS)+1:0]   rem_out,
  output logic [sfc_pkg::root_width(COORD_BITS)-1:0]   root_out,
  output logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::dist_width(COORD_BITS, NORMAL_FRAC_BITS)-1:0]
               dist_out
);

  localparam int TW  = sfc_pkg::root_width(COORD_BITS);
  localparam int XW  = 2 * TW;
  localparam int RMW = TW + 2;
  localparam int BPS = sfc_pkg::ROOT_BITS_PER_STAGE;

  logic [XW-1:0]  rad_next;
  logic [RMW-1:0] rem_next;
  logic [TW-1:0]  root_next;

  always_comb begin
    logic [RMW+1:0] t;
    logic [RMW+1:0] trial;
    rad_next  = rad_in;
    rem_next  = rem_in;
    root_next = root_in;
    for (int j = 0; j < BPS; j++) begin
      t     = {rem_next, rad_next[XW-1 -: 2]};
      trial = (RMW+2)'({root_next, 2'b01});
      if (t >= trial) begin
        rem_next  = RMW'(t - trial);
        root_next = {root_next[TW-2:0], 1'b1};
      end else begin
        rem_next  = t[RMW-1:0];
        root_next = {root_next[TW-2:0], 1'b0};
      end
      rad_next = {rad_next[XW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_out  <= rad_next;
      rem_out  <= rem_next;
      root_out <= root_next;
      dist_out <= dist_in;
    end
  end

endmodule

// ----- hdl/sfc_classify.sv -----
// Final stage: compare distances against the radius and register the verdict.
module sfc_classify #(
  parameter int COORD_BITS       = sfc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = sfc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic ortho_mode,
  input  logic valid_in,
  input  logic [sfc_pkg::root_width(COORD_BITS)-1:0] root,
  input  logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::dist_width(COORD_BITS, NORMAL_FRAC_BITS)-1:0]
               plane_dist,
  output logic       valid,
  output logic [1:0] verdict
);

  localparam int TW = sfc_pkg::root_width(COORD_BITS);
  localparam int DW = sfc_pkg::dist_width(COORD_BITS, NORMAL_FRAC_BITS);
  localparam int CW = sfc_pkg::max2(DW, TW + NORMAL_FRAC_BITS + 1) + 1;
  localparam int NP = sfc_pkg::NUM_PLANES;

  logic signed [CW-1:0] rr;
  logic       fullin;
  logic       partin;
  logic [1:0] verdict_next;

  assign rr = CW'({root, {NORMAL_FRAC_BITS{1'b0}}});

  always_comb begin
    logic signed [CW-1:0] dd;
    logic signed [CW-1:0] s_hi;
    logic signed [CW-1:0] s_lo;
    logic                 active;
    fullin = 1'b1;
    partin = 1'b1;
    for (int p = 0; p < NP; p++) begin
      dd     = CW'($signed(plane_dist[p]));
      s_hi   = dd + rr;
      s_lo   = dd - rr;
      active = (p < sfc_pkg::PERSP_PLANES) || ortho_mode;
      if (active && !(s_hi[CW-1] || (s_hi == '0))) begin
        fullin = 1'b0;
      end
      if (active && !(s_lo[CW-1] || (s_lo == '0))) begin
        partin = 1'b0;
      end
    end
    if (fullin) begin
      verdict_next = sfc_pkg::VERDICT_INSIDE;
    end else if (partin) begin
      verdict_next = sfc_pkg::VERDICT_PARTIAL;
    end else begin
      verdict_next = sfc_pkg::VERDICT_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict <= verdict_next;
    end
  end

endmodule

// ----- hdl/sphere_frustum_classify_unit.sv -----
// Top level of the sphere frustum classifier: register file, front, root pipeline, verdict.
//
//   channel  signals                                   direction  beat when
//   in       in_valid in_stall center_* extent_*       sink       in_valid && !in_stall
//   out      out_valid out_stall verdict               source     out_valid && !out_stall
//   cfg      cfg_valid cfg_ready cfg_index cfg_data    sink       cfg_valid && cfg_ready
//
// One beat per cycle in and out while the output is not stalled. The square root pipeline
// settles four root bits per stage, between the front stages and the verdict register.
// Reset clears all valid bits and config registers; cfg_ready is always high.
// A stalled output freezes every stage; in_stall follows a full, stalled output register.
module sphere_frustum_classify_unit #(
  parameter int COORD_BITS       = sfc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = sfc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       center_x,
  input  logic signed [COORD_BITS-1:0]       center_y,
  input  logic signed [COORD_BITS-1:0]       center_z,
  input  logic [COORD_BITS-2:0]              extent_x,
  input  logic [COORD_BITS-2:0]              extent_y,
  input  logic [COORD_BITS-2:0]              extent_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         verdict,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sfc_pkg::PLANE_BITS-1:0]     cfg_data
);

  localparam int TW  = sfc_pkg::root_width(COORD_BITS);
  localparam int XW  = 2 * TW;
  localparam int RMW = TW + 2;
  localparam int SQ  = sfc_pkg::root_stages(COORD_BITS);
  localparam int DW  = sfc_pkg::dist_width(COORD_BITS, NORMAL_FRAC_BITS);
  localparam int NP  = sfc_pkg::NUM_PLANES;

  logic adv;
  logic ortho_mode;
  logic [NP-1:0][sfc_pkg::PLANE_BITS-1:0] planes;

  logic                  front_valid;
  logic [2*COORD_BITS-1:0] sumsq;
  logic [NP-1:0][DW-1:0] front_dist;

  logic                  valid_s [SQ+1];
  logic [XW-1:0]         rad_s   [SQ+1];
  logic [RMW-1:0]        rem_s   [SQ+1];
  logic [TW-1:0]         root_s  [SQ+1];
  logic [NP-1:0][DW-1:0] dist_s  [SQ+1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  sfc_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ortho_mode (ortho_mode),
    .planes     (planes)
  );

  sfc_front #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .extent_x   (extent_x),
    .extent_y   (extent_y),
    .extent_z   (extent_z),
    .planes     (planes),
    .valid      (front_valid),
    .sumsq      (sumsq),
    .plane_dist (front_dist)
  );

  assign valid_s[0] = front_valid;
  assign rad_s[0]   = XW'(sumsq);
  assign rem_s[0]   = '0;
  assign root_s[0]  = '0;
  assign dist_s[0]  = front_dist;

  for (genvar s = 0; s < SQ; s++) begin : g_root
    sfc_root_stage #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .valid_in  (valid_s[s]),
      .rad_in    (rad_s[s]),
      .rem_in    (rem_s[s]),
      .root_in   (root_s[s]),
      .dist_in   (dist_s[s]),
      .valid_out (valid_s[s+1]),
      .rad_out   (rad_s[s+1]),
      .rem_out   (rem_s[s+1]),
      .root_out  (root_s[s+1]),
      .dist_out  (dist_s[s+1])
    );
  end

  sfc_classify #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_classify (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ortho_mode (ortho_mode),
    .valid_in   (valid_s[SQ]),
    .root       (root_s[SQ]),
    .plane_dist (dist_s[SQ]),
    .valid      (out_valid),
    .verdict    (verdict)
  );

  a_stall_only_when_full: assert property (@(posedge clk)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == sfc_pkg::VERDICT_INSIDE ||
                   verdict == sfc_pkg::VERDICT_PARTIAL ||
                   verdict == sfc_pkg::VERDICT_OUTSIDE))
    else $error("verdict code out of range");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid && !front_valid)
    else $error("pipeline holds a beat after reset");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for sphere_frustum_classify_unit: directed and random nodes checked by an in-bench classifier.
module tb;

  localparam int COORD_W = sfc_pkg::COORD_BITS_DEF;
  localparam int FRAC_W = sfc_pkg::NORMAL_FRAC_BITS_DEF;
  localparam int NRM_W = FRAC_W + 2;
  localparam int OFS_W = sfc_pkg::PLANE_BITS - 3 * NRM_W;
  localparam int NRM_ONE = 1 << FRAC_W;
  localparam longint UNIT = longint'(1) << FRAC_W;
  localparam int PIPE_LATENCY = 3 + sfc_pkg::root_stages(COORD_W);
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_NODES = 95;
  localparam logic [sfc_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;

  typedef logic [sfc_pkg::PLANE_BITS-1:0] plane_set_t [sfc_pkg::NUM_PLANES];

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [COORD_W-2:0] extent_x;
  logic [COORD_W-2:0] extent_y;
  logic [COORD_W-2:0] extent_z;
  logic out_valid;
  logic out_stall;
  logic [1:0] verdict;
  logic cfg_valid;
  logic cfg_ready;
  logic [sfc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [sfc_pkg::PLANE_BITS-1:0] cfg_data;

  logic view_ortho;
  plane_set_t view_planes;
  logic [1:0] pending_verdicts[$];
  logic [1:0] want_verdict;
  int send_idle_pct;
  int stall_pct;
  int errors = 0;
  int nodes_sent = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int verdict_tally[3] = '{0, 0, 0};

  sphere_frustum_classify_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .center_x(center_x),
    .center_y(center_y),
    .center_z(center_z),
    .extent_x(extent_x),
    .extent_y(extent_y),
    .extent_z(extent_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned floor_root(input longint unsigned sq);
    longint unsigned r;
    r = longint'($floor($sqrt(real'(sq))));
    while (r * r > sq) r--;
    while ((r + 1) * (r + 1) <= sq) r++;
    return r;
  endfunction

  function automatic logic [1:0] classify_node(
    input logic signed [COORD_W-1:0] cx, cy, cz,
    input logic [COORD_W-2:0] ex, ey, ez
  );
    longint ctr[3];
    longint radius;
    longint sdist;
    logic signed [NRM_W-1:0] nrm;
    logic signed [OFS_W-1:0] ofs;
    bit fully_in;
    bit partly_in;
    int nplanes;
    ctr[0] = cx;
    ctr[1] = cy;
    ctr[2] = cz;
    radius = longint'(floor_root(longint'(ex) * ex + longint'(ey) * ey + longint'(ez) * ez))
             * UNIT;
    nplanes = view_ortho ? sfc_pkg::NUM_PLANES : sfc_pkg::PERSP_PLANES;
    fully_in = 1'b1;
    partly_in = 1'b1;
    for (int i = 0; i < nplanes; i++) begin
      sdist = 0;
      for (int k = 0; k < 3; k++) begin
        nrm = view_planes[i][k*NRM_W +: NRM_W];
        sdist += nrm * ctr[k];
      end
      ofs = view_planes[i][3*NRM_W +: OFS_W];
      sdist -= ofs * UNIT;
      if (sdist + radius > 0) fully_in = 1'b0;
      if (sdist - radius > 0) partly_in = 1'b0;
    end
    return fully_in ? sfc_pkg::VERDICT_INSIDE :
           (partly_in ? sfc_pkg::VERDICT_PARTIAL : sfc_pkg::VERDICT_OUTSIDE);
  endfunction

  function automatic logic [sfc_pkg::PLANE_BITS-1:0] pack_plane(input int nx, ny, nz, ofs);
    return {OFS_W'(ofs), NRM_W'(nz), NRM_W'(ny), NRM_W'(nx)};
  endfunction

  function automatic plane_set_t box_planes(input int half);
    plane_set_t ps;
    ps[0] = pack_plane(0, 0, NRM_ONE, half);
    ps[1] = pack_plane(0, 0, -NRM_ONE, half);
    ps[2] = pack_plane(NRM_ONE, 0, 0, half);
    ps[3] = pack_plane(-NRM_ONE, 0, 0, half);
    ps[4] = pack_plane(0, NRM_ONE, 0, half);
    ps[5] = pack_plane(0, -NRM_ONE, 0, half);
    return ps;
  endfunction

  function automatic plane_set_t random_box(input int half);
    plane_set_t ps;
    int nrm[3];
    int axis;
    int sgn;
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      axis = (p < 2) ? 2 : ((p < 4) ? 0 : 1);
      sgn = (p % 2) ? -1 : 1;
      for (int k = 0; k < 3; k++) begin
        if (k == axis) begin
          nrm[k] = sgn * int'($urandom_range(3600, NRM_ONE));
        end else if ($urandom_range(1, 0)) begin
          nrm[k] = int'($urandom_range(0, 1200)) - 600;
        end else begin
          nrm[k] = 0;
        end
      end
      ps[p] = pack_plane(nrm[0], nrm[1], nrm[2], half + int'($urandom_range(0, 2000)) - 1000);
    end
    return ps;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
             pending_verdicts.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict beat with nothing pending: actual %0d", verdict);
        errors++;
      end else begin
        want_verdict = pending_verdicts.pop_front();
        verdict_tally[want_verdict]++;
        if (verdict !== want_verdict) begin
          $error("verdict mismatch: expected %0d, actual %0d", want_verdict, verdict);
          errors++;
        end
      end
    end
  end

  task automatic send_node(
    input logic signed [COORD_W-1:0] cx, cy, cz,
    input logic [COORD_W-2:0] ex, ey, ez
  );
    center_x <= cx;
    center_y <= cy;
    center_z <= cz;
    extent_x <= ex;
    extent_y <= ey;
    extent_z <= ez;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_verdicts = {pending_verdicts, classify_node(cx, cy, cz, ex, ey, ez)};
    nodes_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random_node(input int span);
    int c[3];
    int e[3];
    if ($urandom_range(99) < 20) begin
      send_node(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                (COORD_W-1)'($urandom), (COORD_W-1)'($urandom), (COORD_W-1)'($urandom));
    end else begin
      for (int k = 0; k < 3; k++) begin
        c[k] = clamp_coord(int'($urandom_range(0, 2 * span)) - span);
        e[k] = $urandom_range(0, (1 << $urandom_range(0, COORD_W - 1)) - 1);
      end
      send_node(COORD_W'(c[0]), COORD_W'(c[1]), COORD_W'(c[2]),
                (COORD_W-1)'(e[0]), (COORD_W-1)'(e[1]), (COORD_W-1)'(e[2]));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfc_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [sfc_pkg::PLANE_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sfc_pkg::REG_ORTHO_MODE) begin
      view_ortho = data[0];
    end else if (idx < sfc_pkg::REG_PLANE_FIRST + sfc_pkg::NUM_PLANES) begin
      view_planes[idx - sfc_pkg::REG_PLANE_FIRST] = data;
    end
    reg_writes++;
  endtask

  task automatic load_view(input logic [sfc_pkg::PLANE_BITS-1:0] mode_word,
                           input plane_set_t planes);
    drain_results();
    write_reg(sfc_pkg::REG_ORTHO_MODE, mode_word);
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      write_reg(sfc_pkg::REG_PLANE_FIRST + sfc_pkg::CFG_INDEX_BITS'(p), planes[p]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_idle_pct = 0;
    stall_pct = 0;
    send_node(0, 0, 0, 0, 0, 0);
    send_node(32767, -32768, 100, 32767, 32767, 32767);
    send_node(-32768, 32767, -32768, 0, 0, 1);
  endtask

  task automatic test_axis_box();
    load_view(64'd0, box_planes(1000));
    send_node(0, 0, 0, 10, 10, 10);
    send_node(990, 0, 0, 10, 0, 0);
    send_node(991, 0, 0, 10, 0, 0);
    send_node(1010, 0, 0, 10, 0, 0);
    send_node(1011, 0, 0, 10, 0, 0);
    send_node(0, -5000, 0, 1, 1, 1);
    load_view(64'd1, box_planes(1000));
    send_node(0, -5000, 0, 1, 1, 1);
    send_node(0, 0, 0, 3, 4, 0);
    send_node(0, -998, 0, 3, 4, 0);
  endtask

  task automatic test_special_planes();
    plane_set_t ps;
    drain_results();
    write_reg(REG_UNMAPPED, '1);
    cfg_valid <= 1'b0;
    send_node(0, 0, 0, 0, 0, 0);
    send_node(0, -5000, 0, 1, 1, 1);
    ps = box_planes(1000);
    load_view(64'hFFFF_FFFF_FFFF_FFFE, ps);
    send_node(0, -5000, 0, 1, 1, 1);
    ps[5] = pack_plane(0, 0, 0, -1);
    load_view(64'd0, ps);
    send_node(0, 0, 0, 5, 5, 5);
    ps[4] = pack_plane(0, 0, 0, 0);
    load_view(64'd0, ps);
    send_node(0, 0, 0, 0, 0, 0);
    send_node(0, 0, 0, 1, 0, 0);
    load_view(64'd1, ps);
    send_node(0, 0, 0, 0, 0, 0);
    ps[0] = pack_plane(-8192, 8191, -8192, -(1 << 21));
    ps[1] = pack_plane(8191, -8192, 8191, (1 << 21) - 1);
    ps[2] = pack_plane(8191, 8191, 8191, (1 << 21) - 1);
    ps[3] = pack_plane(-8192, -8192, -8192, -(1 << 21));
    ps[4] = '1;
    ps[5] = '0;
    load_view(64'd1, ps);
    send_node(32767, -32768, 32767, 32767, 0, 32767);
    send_node(-32768, -32768, -32768, 0, 0, 0);
    send_node(32767, 32767, 32767, 32767, 32767, 32767);
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct_in);
    plane_set_t ps;
    int half;
    send_idle_pct = send_pct;
    stall_pct = stall_pct_in;
    for (int s = 0; s < 2; s++) begin
      half = $urandom_range(8, 16000);
      if ($urandom_range(3) == 0) begin
        for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) ps[p] = {$urandom, $urandom};
      end else begin
        ps = random_box(half);
      end
      load_view({$urandom, $urandom} & ~64'd1 | 64'(s), ps);
      for (int n = 0; n < RANDOM_NODES; n++) send_random_node(half * 3 / 2 + 64);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    center_x = '0;
    center_y = '0;
    center_z = '0;
    extent_x = '0;
    extent_y = '0;
    extent_z = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    view_ortho = 1'b0;
    view_planes = '{default: '0};
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_axis_box();
    test_special_planes();
    test_random_traffic(0, 0);
    test_random_traffic(75, 0);
    test_random_traffic(0, 75);
    test_random_traffic(14, 14);
    drain_results();
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    $display("Covered %0d nodes under %0d register writes, perspective and ortho views.",
             nodes_sent, reg_writes);
    $display("Verdicts seen: %0d inside, %0d partial, %0d outside.",
             verdict_tally[0], verdict_tally[1], verdict_tally[2]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
